[src/spectrum_trace_detector_assert.svh]
// Assertion macros shared by the trace detector RTL.
// Each check samples on the rising edge of clk and is off while rst is high.
`ifndef SPECTRUM_TRACE_DETECTOR_ASSERT_SVH
`define SPECTRUM_TRACE_DETECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trace detector check failed");
`define STD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trace detector check failed");
`else
`define STD_ASSERT_SAME(lbl, ante, cons)
`define STD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/spec_trc_pkg.sv]
package spec_trc_pkg;

  localparam int BIN_W     = 14;
  localparam int PWR_W     = 16;
  localparam int WGT_W     = 17;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W   = 32;
  localparam int RANGE_W   = 17;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [WGT_W-1:0]     weight_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Trace mode codes; the spare code behaves as averaging.
  localparam mode_t MODE_PEAK = 2'd0;
  localparam mode_t MODE_MIN  = 2'd1;
  localparam mode_t MODE_AVG  = 2'd2;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_TRACE_MODE = 1'd0;
  localparam cfg_idx_t REG_AVG_WEIGHT = 1'd1;

  // Unity weight in unsigned Q1.16.
  localparam weight_t WEIGHT_ONE = 17'd65536;

endpackage

[src/spectrum_trace_detector.sv]
// An accepted item passes through stages A, B and C and the output register to m_tvalid.
// Throughput: one item per cycle when m_tready does not stall the pipeline; an in-range item
// whose bin matches one of the two items ahead of it in stages B and C waits until that item
// has written its trace. Reset (rst, synchronous, active high) clears control state, restores
// trace_mode to 2 and avg_weight to one, then sweeps every trace memory word with s_tready low.
`include "spectrum_trace_detector_assert.svh"

module spectrum_trace_detector #(
  parameter int NUM_BINS = 16384
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [spec_trc_pkg::TDATA_W-1:0]  s_tdata,   // bin [13:0], power_db [29:14], zero
  // Result items.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [spec_trc_pkg::TDATA_W-1:0]  m_tdata,   // bin_out [13:0], trace_db [29:14], zero
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spec_trc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spec_trc_pkg::WGT_W-1:0]    cfg_data
);

  import spec_trc_pkg::*;

  // The memory holds one word per bin: a written flag above the 16-bit trace.
  localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int WORD_W = PWR_W + 1;
  localparam logic [RANGE_W-1:0] BIN_LIMIT = RANGE_W'(NUM_BINS);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(NUM_BINS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------------------
  mode_t   trace_mode;
  weight_t avg_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_mode <= MODE_AVG;
      avg_weight <= WEIGHT_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRACE_MODE: trace_mode <= cfg_data[MODE_W-1:0];
        REG_AVG_WEIGHT: avg_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass. After reset every word is written with its flag low, one
  // address per cycle, before the first item is taken.
  // ---------------------------------------------------------------------------
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpacking.
  // ---------------------------------------------------------------------------
  logic [BIN_W-1:0]  s_bin;
  logic [PWR_W-1:0]  s_pow;
  logic [ADDR_W-1:0] s_addr;
  logic              s_inr;
  logic              accept;

  assign s_bin  = s_tdata[BIN_W-1:0];
  assign s_pow  = s_tdata[BIN_W+PWR_W-1:BIN_W];
  assign s_addr = ADDR_W'(s_bin);
  assign s_inr  = (RANGE_W'(s_bin) < BIN_LIMIT);
  assign accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Pipeline registers. Stage A holds the item while its memory word is read,
  // stage B holds the compare and difference, stage C the weighted product,
  // and the output register the finished result.
  // ---------------------------------------------------------------------------
  logic                     a_valid, b_valid, c_valid, o_valid;
  logic [BIN_W-1:0]         a_bin, b_bin, c_bin;
  logic [PWR_W-1:0]         a_pow;
  logic                     a_inr, b_inr, c_inr;
  logic [WORD_W-1:0]        rdata;
  logic                     a_fwd;
  logic [WORD_W-1:0]        a_fwd_data;

  logic signed [PWR_W-1:0]  b_old, c_old;
  logic signed [PWR_W:0]    b_diff;
  logic [PWR_W-1:0]         b_pre, c_pre;
  logic                     b_avg, c_avg;
  weight_t                  b_w;
  logic signed [WGT_W+PWR_W+1:0] c_prod;

  logic [BIN_W-1:0]         o_bin;
  logic [PWR_W-1:0]         o_trace;

  // Handshake chain from the output register back to the input.
  logic o_free, c_adv, c_free, b_adv, b_free, a_adv, a_free, hazard;

  assign o_free = !o_valid || m_tready;
  assign c_adv  = c_valid && o_free;
  assign c_free = !c_valid || c_adv;
  assign b_adv  = b_valid && c_free;
  assign b_free = !b_valid || b_adv;

  // An item may not read its old trace while an earlier item for the same bin
  // is still in stage B or C; the stored word is not final until C writes it.
  assign hazard = a_valid && a_inr &&
                  ((b_valid && b_inr && (b_bin == a_bin)) ||
                   (c_valid && c_inr && (c_bin == a_bin)));
  assign a_adv  = a_valid && !hazard && b_free;
  assign a_free = !a_valid || a_adv;

  assign s_tready = a_free && !clearing;

  // ---------------------------------------------------------------------------
  // Trace memory: one write port (clearing or stage C), one registered read.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] mem [NUM_BINS];
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [PWR_W-1:0]  c_trace;

  assign we    = clearing || (c_adv && c_inr);
  assign waddr = clearing ? clr_addr : ADDR_W'(c_bin);
  assign wdata = clearing ? '0 : {1'b1, c_trace};

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[s_addr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A write that lands on the bin held in stage A, at its read or while it
  // waits, replaces the word read from memory.
  logic [ADDR_W-1:0] a_addr_next;
  logic              fwd_hit;

  assign a_addr_next = accept ? s_addr : ADDR_W'(a_bin);
  assign fwd_hit     = we && (waddr == a_addr_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_fwd <= 1'b0;
    end else if (accept) begin
      a_fwd <= fwd_hit;
    end else if (fwd_hit) begin
      a_fwd <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_hit) begin
      a_fwd_data <= wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        c_valid <= 1'b1;
      end else if (c_adv) begin
        c_valid <= 1'b0;
      end
      if (c_adv) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A load.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      a_bin <= s_bin;
      a_pow <= s_pow;
      a_inr <= s_inr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: pick the old word, take the difference, and settle the peak,
  // minimum and first-write cases. Out-of-range bins pass the power through.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]       old_word;
  logic signed [PWR_W-1:0] new_v, old_v;
  logic                    written;
  logic [PWR_W-1:0]        pre_v;
  logic                    avg_v;
  weight_t                 w_sat;

  assign old_word = a_fwd ? a_fwd_data : rdata;
  assign new_v    = $signed(a_pow);
  assign old_v    = $signed(old_word[PWR_W-1:0]);
  assign written  = old_word[PWR_W];
  assign w_sat    = (avg_weight > WEIGHT_ONE) ? WEIGHT_ONE : avg_weight;

  always_comb begin
    pre_v = a_pow;
    avg_v = 1'b0;
    if (a_inr && written) begin
      case (trace_mode)
        MODE_PEAK: pre_v = (new_v > old_v) ? a_pow : old_word[PWR_W-1:0];
        MODE_MIN:  pre_v = (new_v < old_v) ? a_pow : old_word[PWR_W-1:0];
        default:   avg_v = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_bin  <= a_bin;
      b_inr  <= a_inr;
      b_old  <= old_v;
      b_diff <= {new_v[PWR_W-1], new_v} - {old_v[PWR_W-1], old_v};
      b_pre  <= pre_v;
      b_avg  <= avg_v;
      b_w    <= w_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: weight times difference, 18 x 17 bits signed.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_bin  <= b_bin;
      c_inr  <= b_inr;
      c_old  <= b_old;
      c_pre  <= b_pre;
      c_avg  <= b_avg;
      c_prod <= $signed({1'b0, b_w}) * b_diff;
    end
  end

  // The arithmetic shift floors toward minus infinity. The average always lies
  // between the old and new values, so 16 bits of the sum suffice.
  logic signed [WGT_W+PWR_W+1:0] c_quot;

  assign c_quot  = c_prod >>> 16;
  assign c_trace = c_avg ? PWR_W'(c_old + c_quot[PWR_W-1:0]) : c_pre;

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (c_adv) begin
      o_bin   <= c_bin;
      o_trace <= c_trace;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {{(TDATA_W-BIN_W-PWR_W){1'b0}}, o_trace, o_bin};

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `STD_ASSERT_SAME(a_no_accept_clearing, clearing, !s_tready)
  `STD_ASSERT_SAME(a_pipe_empty_clearing, clearing, !a_valid && !b_valid && !c_valid)
  `STD_ASSERT_SAME(a_no_same_bin_bc, b_valid && c_valid && b_inr && c_inr, b_bin != c_bin)
  `STD_ASSERT_NEXT(a_hazard_holds_a, hazard, a_valid)

endmodule

[sim/tb_spectrum_trace_detector.sv]
`timescale 1ns / 100ps

module tb_spectrum_trace_detector;
  import spec_trc_pkg::*;

  // The block runs with its full trace memory, one word for every value of the bin field.
  localparam int NUM_BINS = 16384;

  // The package names no code for the fourth mode; the block treats it as averaging.
  localparam mode_t MODE_SPARE = 2'd3;

  localparam int RUN_SETTINGS    = 5;    // register settings per idling phase
  localparam int ITEMS_PER_SETUP = 130;  // random items under one setting
  localparam int DRAIN_CYCLES    = 12;   // extra cycles that watch for stray results

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table. An item row uses bin and the low 16 bits of val as
  // the power; a configuration row writes val to register idx. When typed is set, the
  // trace value of the result is the one given in exp_db.
  typedef struct packed {
    row_kind_t         kind;
    cfg_idx_t          idx;
    logic [BIN_W-1:0]  bin;
    logic [WGT_W-1:0]  val;
    logic              typed;
    logic [PWR_W-1:0]  exp_db;
  } row_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [PWR_W-1:0] db;
  } trace_item_t;

  localparam int DIR_ROWS = 29;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = REG_TRACE_MODE;
  logic [WGT_W-1:0]      cfg_data = '0;

  // Shadow copy of the block's state, kept in step with every accepted item and write.
  logic signed [PWR_W-1:0] trace_mem [NUM_BINS];
  bit                      bin_seen  [NUM_BINS];
  mode_t                   cur_mode   = MODE_AVG;
  weight_t                 cur_weight = WEIGHT_ONE;

  // Trace values still owed by the block, oldest first.
  trace_item_t pending_traces [$];

  int mismatches    = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 64;

  row_t plan [DIR_ROWS];

  spectrum_trace_detector #(
    .NUM_BINS (NUM_BINS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop. The limit lies far beyond the reset sweep plus the slowest correct run.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Applies one item to the shadow state and returns the trace value the block must
  // report. A bin past the end of the memory passes its power through untouched, the
  // first value of a bin is taken as it is, and later values follow the mode.
  function automatic logic signed [PWR_W-1:0] update_trace(input logic [BIN_W-1:0] b,
                                                           input logic signed [PWR_W-1:0] p);
    logic signed [PWR_W-1:0] old_v;
    logic signed [PWR_W-1:0] t;
    weight_t                 w;
    longint                  prod;
    if (int'(b) >= NUM_BINS) return p;
    if (!bin_seen[b]) begin
      bin_seen[b]  = 1'b1;
      trace_mem[b] = p;
      return p;
    end
    old_v = trace_mem[b];
    case (cur_mode)
      MODE_PEAK: t = (p > old_v) ? p : old_v;
      MODE_MIN:  t = (p < old_v) ? p : old_v;
      default: begin
        // Averaging, also for the spare mode. Weights above one count as one, and the
        // arithmetic shift gives the floor toward minus infinity.
        w    = (cur_weight > WEIGHT_ONE) ? WEIGHT_ONE : cur_weight;
        prod = longint'(w) * (longint'(p) - longint'(old_v));
        t    = PWR_W'(longint'(old_v) + (prod >>> 16));
      end
    endcase
    trace_mem[b] = t;
    return t;
  endfunction

  // Offers one item, after a random number of idle cycles, and books its result once
  // the block takes it. Left just after a rising edge.
  task automatic send_item(input logic [BIN_W-1:0] b, input logic [PWR_W-1:0] p,
                           input logic typed, input logic [PWR_W-1:0] exp_db);
    trace_item_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-BIN_W-PWR_W){1'b0}}, p, b};
    do @(posedge clk); while (!s_tready);
    want.bin = b;
    want.db  = update_trace(b, p);
    if (typed) want.db = exp_db;
    pending_traces.push_back(want);
  endtask

  // Register write. The item stream is stopped first and every result owed is collected,
  // so the block is idle when the new setting lands.
  task automatic write_reg(input cfg_idx_t idx, input logic [WGT_W-1:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_traces.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TRACE_MODE) cur_mode = mode_t'(data[MODE_W-1:0]);
    else cur_weight = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The receiver stalls at random with the rate of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result is checked against the oldest trace value still owed.
  always @(posedge clk) begin : check_results
    trace_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_traces.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing owed: bin %0d trace %0d", $time,
                 m_tdata[BIN_W-1:0], $signed(m_tdata[BIN_W+PWR_W-1:BIN_W]));
      end else begin
        want = pending_traces.pop_front();
        if (m_tdata[BIN_W-1:0] !== want.bin) begin
          mismatches++;
          $display("%0t: bin_out expected %0d got %0d", $time, want.bin,
                   m_tdata[BIN_W-1:0]);
        end
        if (m_tdata[BIN_W+PWR_W-1:BIN_W] !== want.db) begin
          mismatches++;
          $display("%0t: trace_db of bin %0d expected %0d got %0d", $time, want.bin,
                   $signed(want.db), $signed(m_tdata[BIN_W+PWR_W-1:BIN_W]));
        end
      end
    end
  end

  initial begin : stimulus
    logic [BIN_W-1:0] pool [8];
    logic [BIN_W-1:0] b;
    logic [BIN_W-1:0] prev1;
    logic [BIN_W-1:0] prev2;
    logic [PWR_W-1:0] p;
    logic [WGT_W-1:0] w;
    int               r;

    // Directed table. The first value of a bin comes back unchanged, so those rows
    // carry their answer; the rest use the shadow.
    plan = '{
      // Averaging at unity weight straight after reset: extremes and the last bin.
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h07FFF, 1'b1, 16'h7FFF},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h08000, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd16383, 17'h08000, 1'b1, 16'h8000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd8191,  17'h01234, 1'b1, 16'h1234},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd8192,  17'h07FFF, 1'b1, 16'h7FFF},
      // Peak hold.
      '{ROW_CFG,  REG_TRACE_MODE, 14'd0,     17'(MODE_PEAK), 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h07FFF, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h0FFFB, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd8191,  17'h01233, 1'b0, 16'h0000},
      // Minimum hold.
      '{ROW_CFG,  REG_TRACE_MODE, 14'd0,     17'(MODE_MIN), 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h08000, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h00064, 1'b0, 16'h0000},
      // Averaging with zero weight, then half weight in both directions.
      '{ROW_CFG,  REG_TRACE_MODE, 14'd0,     17'(MODE_AVG), 1'b0, 16'h0000},
      '{ROW_CFG,  REG_AVG_WEIGHT, 14'd0,     17'd0,     1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h07FFF, 1'b0, 16'h0000},
      '{ROW_CFG,  REG_AVG_WEIGHT, 14'd0,     17'd32768, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h07FFF, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h08000, 1'b0, 16'h0000},
      // Weight above one saturates; the spare mode averages.
      '{ROW_CFG,  REG_AVG_WEIGHT, 14'd0,     17'h1FFFF, 1'b0, 16'h0000},
      '{ROW_CFG,  REG_TRACE_MODE, 14'd0,     17'(MODE_SPARE), 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd0,     17'h003E8, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd1,     17'h00001, 1'b1, 16'h0001},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd1,     17'h0FFFF, 1'b0, 16'h0000},
      // Smallest nonzero weight: a negative step still moves by one.
      '{ROW_CFG,  REG_AVG_WEIGHT, 14'd0,     17'd1,     1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd1,     17'h08000, 1'b0, 16'h0000},
      // Alternating bit patterns, same bin back to back, and two fresh bins.
      '{ROW_ITEM, REG_TRACE_MODE, 14'd2,     17'h05555, 1'b1, 16'h5555},
      '{ROW_ITEM, REG_TRACE_MODE, 14'd2,     17'h02AAA, 1'b0, 16'h0000},
      '{ROW_ITEM, REG_TRACE_MODE, 14'h2AAA,  17'h02AAA, 1'b1, 16'h2AAA},
      '{ROW_ITEM, REG_TRACE_MODE, 14'h1555,  17'h05555, 1'b1, 16'h5555}
    };

    // Reset once, then the block sweeps its memory with s_tready low; the handshakes
    // simply wait that out.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].val);
      else send_item(plan[i].bin, plan[i].val[PWR_W-1:0], plan[i].typed, plan[i].exp_db);
    end

    // Random part: three idling phases, each walking through several register settings.
    prev1 = '0;
    prev2 = '0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 26; recv_idle_pct = 64; end
        1: begin send_idle_pct = 64; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < RUN_SETTINGS; s++) begin
        // Mode in the low bits, noise above them.
        write_reg(REG_TRACE_MODE, {15'($urandom), 2'($urandom_range(3))});
        case ($urandom_range(6))
          0: w = '0;
          1: w = 17'd1;
          2: w = 17'd65535;
          3: w = WEIGHT_ONE;
          4: w = '1;
          default: w = 17'($urandom);
        endcase
        write_reg(REG_AVG_WEIGHT, w);

        // A small set of bins keeps most items landing on bins that already hold a trace.
        foreach (pool[k]) pool[k] = BIN_W'($urandom_range(NUM_BINS - 1));
        pool[0] = '0;
        pool[1] = BIN_W'(NUM_BINS - 1);

        for (int n = 0; n < ITEMS_PER_SETUP; n++) begin
          r = $urandom_range(99);
          if (r < 10)      b = prev1;                      // same bin as the last item
          else if (r < 18) b = prev2;                      // same bin two items back
          else if (r < 24) b = BIN_W'($urandom);           // anywhere in the bin field
          else             b = pool[$urandom_range(7)];
          r = $urandom_range(99);
          if (r < 6)       p = 16'h7FFF;
          else if (r < 12) p = 16'h8000;
          else if (r < 55) p = 16'($urandom);
          else             p = 16'(int'($urandom_range(24576)) - 20480);  // usual dB range
          send_item(b, p, 1'b0, '0);
          prev2 = prev1;
          prev1 = b;
        end
      end
    end

    // Stop the stream, collect what is owed, then watch a little longer for strays.
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_traces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
